FILE: rtl/core/kspe_pkg.sv
// ---------------------------------------------------------------------------
// kspe_pkg
// Shared types, codes and saturation helpers for the segment profile evaluator.
// ---------------------------------------------------------------------------
package kspe_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // mode codes of an input item
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // status codes of a result
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_QUERY
  } op_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] seg_accel;
    logic [23:0]        seg_duration;
    logic [31:0]        query_time;
  } item_t;

  typedef struct packed {
    logic signed [23:0] accel_out;
    logic signed [31:0] velocity_out;
    logic [31:0]        altitude_out;
    logic [2:0]         segment_index;
    logic [1:0]         status;
  } result_t;

  // classified command between front and back
  typedef struct packed {
    op_t                op;
    logic signed [23:0] accel;
    logic [23:0]        duration;
    logic [31:0]        qtime;
  } cmd_t;

  function automatic logic [31:0] sat_u32(input logic [32:0] x);
    return x[32] ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [40:0] x);
    if ((x[40:31] == '0) || (x[40:31] == '1)) begin
      return x[31:0];
    end
    return {x[40], {31{~x[40]}}};
  endfunction

  function automatic logic signed [39:0] sat_s40(input logic signed [59:0] x);
    if ((x[59:39] == '0) || (x[59:39] == '1)) begin
      return x[39:0];
    end
    return {x[59], {39{~x[59]}}};
  endfunction

  // floor at zero, saturate at all ones
  function automatic logic [31:0] clamp_alt(input logic signed [59:0] x);
    if (x[59]) begin
      return 32'd0;
    end
    if (|x[58:32]) begin
      return 32'hFFFF_FFFF;
    end
    return x[31:0];
  endfunction

endpackage

FILE: rtl/core/kspe_front.sv
// ---------------------------------------------------------------------------
// kspe_front
// Input stage: holds one item, decodes its mode and passes commands on.
// ---------------------------------------------------------------------------
module kspe_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  kspe_pkg::item_t item,
  output logic           q_push,
  input  logic           q_full,
  output kspe_pkg::cmd_t q_data
);

  logic           hold_valid;
  kspe_pkg::item_t hold;
  logic           accept;
  logic           drain;

  assign full   = hold_valid && q_full;
  assign accept = push && !full;
  assign drain  = hold_valid && !q_full;

  // drop unused mode codes, forward the rest
  assign q_push = drain && (hold.mode != kspe_pkg::MODE_UNUSED);

  always_comb begin
    q_data          = '0;
    q_data.accel    = hold.seg_accel;
    q_data.duration = hold.seg_duration;
    q_data.qtime    = hold.query_time;
    unique case (hold.mode)
      kspe_pkg::MODE_CLEAR:  q_data.op = kspe_pkg::OP_CLEAR;
      kspe_pkg::MODE_APPEND: q_data.op = kspe_pkg::OP_APPEND;
      kspe_pkg::MODE_QUERY:  q_data.op = kspe_pkg::OP_QUERY;
      default:               q_data.op = kspe_pkg::OP_CLEAR;
    endcase
  end

  // hold the item until the queue has room
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= (hold_valid && q_full) || accept;
    end
    if (accept) begin
      hold <= item;
    end
  end

endmodule

FILE: rtl/core/kspe_queue.sv
// ---------------------------------------------------------------------------
// kspe_queue
// Short command queue that decouples the front from the back.
// ---------------------------------------------------------------------------
module kspe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  kspe_pkg::cmd_t wdata,
  output logic           full,
  input  logic           rd,
  output logic           valid,
  output kspe_pkg::cmd_t rdata
);

  localparam int unsigned DEPTH = kspe_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  kspe_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  cnt;
  logic           do_wr;
  logic           do_rd;

  assign full  = (cnt == CW'(DEPTH));
  assign valid = (cnt != '0);
  assign rdata = mem[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - CW'(1);
      end
    end
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: rtl/core/kspe_back.sv
// ---------------------------------------------------------------------------
// kspe_back
// Segment table and sequencer: searches, multiplies in steps and answers.
// ---------------------------------------------------------------------------
module kspe_back #(
  parameter int unsigned MAX_SEGMENTS = kspe_pkg::MAX_SEGMENTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  kspe_pkg::cmd_t   q_data,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output kspe_pkg::result_t result
);

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_LOAD,
    S_MUL1,
    S_MUL2,
    S_WIDE,
    S_ALT,
    S_FIN,
    S_RESP
  } state_t;

  // segment table
  logic [31:0]        tbl_start [MAX_SEGMENTS];
  logic signed [31:0] tbl_vel   [MAX_SEGMENTS];
  logic signed [39:0] tbl_alt   [MAX_SEGMENTS];
  logic signed [23:0] tbl_acc   [MAX_SEGMENTS];
  logic [23:0]        tbl_len   [MAX_SEGMENTS];
  logic [CW-1:0]      count;
  logic [31:0]        end_time;

  state_t             state;
  kspe_pkg::cmd_t     cmd;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      sel;
  logic [IW-1:0]      last;

  // operands and partial results
  logic signed [23:0] op_a;
  logic signed [31:0] op_v;
  logic signed [39:0] op_h;
  logic [23:0]        op_t;
  logic [31:0]        op_st;
  logic signed [48:0] at;
  logic signed [56:0] vt;
  logic [47:0]        pl;
  logic signed [49:0] ph;
  logic signed [73:0] att;
  logic signed [59:0] s1;
  logic signed [40:0] vel_sum;
  logic signed [59:0] alt_sum;

  kspe_pkg::result_t  pend;
  kspe_pkg::result_t  res;
  logic               res_valid;

  logic [32:0]        run_end;
  logic signed [32:0] diff;
  logic [IW-1:0]      nxt;

  assign q_pop   = (state == S_IDLE) && q_valid;
  assign empty   = !res_valid;
  assign result  = res;
  assign last    = IW'(count - CW'(1));
  assign run_end = {1'b0, tbl_start[idx]} + {9'd0, tbl_len[idx]};
  assign diff    = $signed({1'b0, cmd.qtime}) - $signed({1'b0, tbl_start[sel]});
  assign nxt     = sel + IW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      end_time  <= '0;
      res_valid <= 1'b0;
      pend      <= '0;
    end else begin
      // refill the output register from the sequencer, or drop a popped beat
      if ((state == S_RESP) && (!res_valid || pop)) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        // decode the next command
        S_IDLE: begin
          if (q_valid) begin
            cmd  <= q_data;
            unique case (q_data.op)
              kspe_pkg::OP_CLEAR: begin
                count    <= '0;
                end_time <= '0;
                state    <= S_RESP;
              end
              kspe_pkg::OP_APPEND: begin
                if (count == CW'(MAX_SEGMENTS)) begin
                  pend.status <= kspe_pkg::STATUS_FULL;
                  state       <= S_RESP;
                end else if (count == '0) begin
                  tbl_start[0] <= '0;
                  tbl_vel[0]   <= '0;
                  tbl_alt[0]   <= '0;
                  tbl_acc[0]   <= q_data.accel;
                  tbl_len[0]   <= q_data.duration;
                  end_time     <= {8'd0, q_data.duration};
                  count        <= CW'(1);
                  state        <= S_RESP;
                end else begin
                  sel   <= last;
                  state <= S_LOAD;
                end
              end
              kspe_pkg::OP_QUERY: begin
                if (count == '0) begin
                  pend.status <= kspe_pkg::STATUS_EMPTY;
                  state       <= S_RESP;
                end else if (q_data.qtime >= end_time) begin
                  sel   <= last;
                  state <= S_LOAD;
                end else begin
                  idx   <= '0;
                  state <= S_SEARCH;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // walk the table for the first running segment
        S_SEARCH: begin
          if (({1'b0, cmd.qtime} < run_end) || (idx == last)) begin
            sel   <= idx;
            state <= S_LOAD;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        // latch segment operands and local time
        S_LOAD: begin
          op_a <= tbl_acc[sel];
          op_v <= tbl_vel[sel];
          op_h <= tbl_alt[sel];
          op_st <= kspe_pkg::sat_u32({1'b0, tbl_start[sel]} + {9'd0, tbl_len[sel]});
          if (cmd.op == kspe_pkg::OP_APPEND) begin
            op_t <= tbl_len[sel];
          end else if (diff[32]) begin
            op_t <= '0;
          end else if (diff > $signed({9'd0, tbl_len[sel]})) begin
            op_t <= tbl_len[sel];
          end else begin
            op_t <= diff[23:0];
          end
          state <= S_MUL1;
        end
        S_MUL1: begin
          at    <= op_a * $signed({1'b0, op_t});
          vt    <= op_v * $signed({1'b0, op_t});
          state <= S_MUL2;
        end
        S_MUL2: begin
          pl      <= at[23:0] * op_t;
          ph      <= $signed(at[48:24]) * $signed({1'b0, op_t});
          s1      <= 60'(op_h) + 60'(vt >>> 10);
          vel_sum <= 41'(op_v) + 41'(at >>> 10);
          state   <= S_WIDE;
        end
        // combine the split product a*t*t
        S_WIDE: begin
          att   <= (74'(ph) <<< 24) + $signed({26'd0, pl});
          state <= S_ALT;
        end
        S_ALT: begin
          alt_sum <= s1 + 60'(att >>> 21);
          state   <= S_FIN;
        end
        // store the new segment or form the query answer
        S_FIN: begin
          if (cmd.op == kspe_pkg::OP_APPEND) begin
            tbl_start[nxt]      <= op_st;
            tbl_vel[nxt]        <= kspe_pkg::sat_s32(vel_sum);
            tbl_alt[nxt]        <= kspe_pkg::sat_s40(alt_sum);
            tbl_acc[nxt]        <= cmd.accel;
            tbl_len[nxt]        <= cmd.duration;
            end_time            <= kspe_pkg::sat_u32({1'b0, op_st} + {9'd0, cmd.duration});
            count               <= count + CW'(1);
            pend.segment_index  <= 3'(nxt);
          end else begin
            pend.accel_out      <= op_a;
            pend.velocity_out   <= kspe_pkg::sat_s32(vel_sum);
            pend.altitude_out   <= kspe_pkg::clamp_alt(alt_sum);
            pend.segment_index  <= 3'(sel);
          end
          state <= S_RESP;
        end
        // hand the result to the output register and clear the staging copy
        S_RESP: begin
          if (!res_valid || pop) begin
            res   <= pend;
            pend  <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/kinematic_segment_profile_evaluator.sv
// ---------------------------------------------------------------------------
// kinematic_segment_profile_evaluator
// Piecewise constant-acceleration profile: append, clear and query segments.
// ---------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      item   (kspe_pkg::item_t)
//  result    pop / empty      result (kspe_pkg::result_t)
//
//  An accepted item passes the front hold, the queue and the back sequencer.
//  A clear, a full append, an empty query or the first append goes straight
//  to the response state; any other append or query passes load, the
//  multiply chain (a*t, then a*t*t split in halves), the wide and altitude
//  sums and finish, and a query whose time lies before the profile end first
//  searches the table (up to MAX_SEGMENTS entries). Reset (rst, synchronous)
//  empties the table, the front hold and the queue. The front holds one item
//  and the queue two more while the back or the result side stalls.
module kinematic_segment_profile_evaluator #(
  parameter int unsigned MAX_SEGMENTS = kspe_pkg::MAX_SEGMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  kspe_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output kspe_pkg::result_t result
);

  logic           q_push;
  logic           q_full;
  kspe_pkg::cmd_t q_wdata;
  logic           q_pop;
  logic           q_valid;
  kspe_pkg::cmd_t q_rdata;

  kspe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wdata)
  );

  kspe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  kspe_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

FILE: tb/sv/tb_kinematic_segment_profile_evaluator.sv
// ---------------------------------------------------------------------------
// tb_kinematic_segment_profile_evaluator
// Drives clear, append and query beats through the segment profile evaluator
// and checks every result against a cycle-free model of the segment table or a directed row.
// ---------------------------------------------------------------------------
module tb_kinematic_segment_profile_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEGS        = kspe_pkg::MAX_SEGMENTS_DEF;
  localparam int          TARGET_ITEMS = 1750;
  localparam int          IDLE_LIMIT  = 5000;
  localparam int          HOLD_CYCLES = 400;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  kspe_pkg::item_t   item;
  logic              empty;
  logic              pop;
  kspe_pkg::result_t result;

  kinematic_segment_profile_evaluator #(.MAX_SEGMENTS(SEGS)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  // table model state
  longint      tbl_start [SEGS];
  longint      tbl_vel   [SEGS];
  longint      tbl_alt   [SEGS];
  longint      tbl_accel [SEGS];
  longint      tbl_len   [SEGS];
  int unsigned tbl_count;
  longint      tbl_end;

  kspe_pkg::result_t pending [$];
  int          errors;
  int          sent;
  int          received;
  int          burst_left;

  // directed rows; fixed rows carry a result readable at a glance
  typedef struct {
    logic [1:0]         mode;
    logic signed [23:0] a;
    logic [23:0]        d;
    logic [31:0]        t;
    bit                 fixed;
    logic [2:0]         idx;
    logic [1:0]         st;
  } dir_row_t;

  localparam int NDIR = 21;
  dir_row_t directed_rows [NDIR];

  initial begin
    directed_rows = '{
      '{kspe_pkg::MODE_QUERY,  24'sd0,        24'd0,      32'd0,        1'b1, 3'd0,
        kspe_pkg::STATUS_EMPTY},
      '{kspe_pkg::MODE_CLEAR,  24'sd0,        24'd0,      32'd0,        1'b1, 3'd0,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_APPEND, 24'sd8388607,  24'hFFFFFF, 32'd0,        1'b1, 3'd0,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_APPEND, -24'sd8388608, 24'd0,      32'd0,        1'b1, 3'd1,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_APPEND, 24'sd0,        24'd1,      32'd0,        1'b1, 3'd2,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_APPEND, -24'sd1,       24'd1000,   32'd0,        1'b1, 3'd3,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_APPEND, 24'sd256,      24'd4096,   32'd0,        1'b1, 3'd4,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_APPEND, -24'sd8388608, 24'hFFFFFF, 32'd0,        1'b1, 3'd5,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_APPEND, 24'sd1234,     24'd77,     32'd0,        1'b1, 3'd6,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_APPEND, -24'sd5,       24'h800000, 32'd0,        1'b1, 3'd7,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_APPEND, 24'sd1,        24'd1,      32'd0,        1'b1, 3'd0,
        kspe_pkg::STATUS_FULL},
      '{kspe_pkg::MODE_QUERY,  24'sd0,        24'd0,      32'd0,        1'b0, 3'd0,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_QUERY,  24'sd0,        24'd0,      32'hFFFFFFFF, 1'b0, 3'd0,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_QUERY,  24'sd0,        24'd0,      32'h00FFFFFF, 1'b0, 3'd0,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_QUERY,  24'sd0,        24'd0,      32'h01000400, 1'b0, 3'd0,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_UNUSED, 24'sd0,        24'd0,      32'd0,        1'b0, 3'd0,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_CLEAR,  24'sd0,        24'd0,      32'd0,        1'b1, 3'd0,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_APPEND, -24'sd8388608, 24'hFFFFFF, 32'd0,        1'b1, 3'd0,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_QUERY,  24'sd0,        24'd0,      32'hFFFFFFFF, 1'b0, 3'd0,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_QUERY,  24'sd0,        24'd0,      32'd12345,    1'b0, 3'd0,
        kspe_pkg::STATUS_OK},
      '{kspe_pkg::MODE_CLEAR,  24'sd0,        24'd0,      32'd0,        1'b1, 3'd0,
        kspe_pkg::STATUS_OK}
    };
  end

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // velocity after local time t, saturated to signed 32 bits
  function automatic longint seg_velocity(int unsigned i, longint t);
    return sat(tbl_vel[i] + ((tbl_accel[i] * t) >>> 10),
               -64'sd2147483648, 64'sd2147483647);
  endfunction

  // unsaturated altitude after local time t; a*t*t is split to stay in 64 bits
  function automatic longint seg_altitude(int unsigned i, longint t);
    longint at, p, q, r, s;
    at = tbl_accel[i] * t;
    p  = at * (t >>> 12);
    q  = p >>> 9;
    r  = p - q * 512;
    s  = r * 4096 + at * (t & 64'd4095);
    return tbl_alt[i] + ((tbl_vel[i] * t) >>> 10) + q + (s >>> 21);
  endfunction

  // advance the table by one beat; has_result is low for the unused mode
  function automatic kspe_pkg::result_t profile_step(kspe_pkg::item_t it,
                                                     output bit has_result);
    kspe_pkg::result_t r;
    int unsigned       n, sel;
    longint            tq, lt;
    r = '0;
    has_result = 1'b1;
    case (it.mode)
      kspe_pkg::MODE_CLEAR: begin
        tbl_count = 0;
        tbl_end   = 0;
      end
      kspe_pkg::MODE_APPEND: begin
        n = tbl_count;
        if (n >= SEGS) begin
          r.status = kspe_pkg::STATUS_FULL;
        end else begin
          if (n == 0) begin
            tbl_start[0] = 0;
            tbl_vel[0]   = 0;
            tbl_alt[0]   = 0;
          end else begin
            tbl_start[n] = sat(tbl_start[n-1] + tbl_len[n-1], 0, 64'hFFFFFFFF);
            tbl_vel[n]   = seg_velocity(n - 1, tbl_len[n-1]);
            tbl_alt[n]   = sat(seg_altitude(n - 1, tbl_len[n-1]),
                               -64'sd549755813888, 64'sd549755813887);
          end
          tbl_accel[n] = longint'(it.seg_accel);
          tbl_len[n]   = longint'(it.seg_duration);
          tbl_end      = sat(tbl_start[n] + tbl_len[n], 0, 64'hFFFFFFFF);
          tbl_count    = n + 1;
          r.segment_index = n[2:0];
        end
      end
      kspe_pkg::MODE_QUERY: begin
        if (tbl_count == 0) begin
          r.status = kspe_pkg::STATUS_EMPTY;
        end else begin
          tq  = longint'(it.query_time);
          sel = tbl_count - 1;
          if (tq < tbl_end) begin
            for (int i = tbl_count - 1; i >= 0; i--) begin
              if (tq < tbl_start[i] + tbl_len[i]) sel = i;
            end
          end
          lt = sat(tq - tbl_start[sel], 0, tbl_len[sel]);
          r.accel_out     = tbl_accel[sel][23:0];
          r.velocity_out  = 32'(seg_velocity(sel, lt));
          r.altitude_out  = 32'(sat(seg_altitude(sel, lt), 0, 64'hFFFFFFFF));
          r.segment_index = sel[2:0];
        end
      end
      default: has_result = 1'b0;
    endcase
    return r;
  endfunction

  // offer one beat, hold it until taken, and record its expected result
  task automatic send_beat(kspe_pkg::item_t it, bit fixed, kspe_pkg::result_t want);
    kspe_pkg::result_t exp_r;
    bit                has;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
    end
    burst_left--;
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    exp_r = profile_step(it, has);
    if (has) begin
      pending.push_back(fixed ? want : exp_r);
      sent++;
    end
  endtask

  task automatic send_pred(kspe_pkg::item_t it);
    send_beat(it, 1'b0, '0);
  endtask

  function automatic logic [23:0] rand_duration();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 24'd0;
    if (k < 8) return 24'($urandom_range(1, 4096));
    return 24'($urandom);
  endfunction

  function automatic logic [23:0] rand_accel();
    if ($urandom_range(0, 1) == 0) return 24'($signed($urandom_range(0, 8192)) - 4096);
    return 24'($urandom);
  endfunction

  // query times cluster inside the profile and on segment boundaries
  function automatic logic [31:0] rand_query_time();
    int     k;
    longint b;
    k = $urandom_range(0, 9);
    if (k < 5 || tbl_count == 0) return 32'($urandom_range(0, 32'(tbl_end + tbl_end / 8 + 2)));
    if (k < 8) begin
      b = tbl_start[$urandom_range(0, tbl_count - 1)];
      return 32'(b + $signed($urandom_range(0, 2)) - 1);
    end
    return $urandom;
  endfunction

  // check every result beat against the oldest expectation
  initial begin
    bit                held;
    int                hold_cnt;
    int                phase;
    kspe_pkg::result_t exp_r;
    pop      = 1'b0;
    held     = 1'b0;
    hold_cnt = 0;
    phase    = 0;
    received = 0;
    errors   = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        received++;
        if (pending.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %p", result);
        end else begin
          exp_r = pending.pop_front();
          if (result.accel_out !== exp_r.accel_out ||
              result.velocity_out !== exp_r.velocity_out ||
              result.altitude_out !== exp_r.altitude_out ||
              result.segment_index !== exp_r.segment_index ||
              result.status !== exp_r.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch beat %0d: expected %p actual %p", received, exp_r, result);
          end
        end
      end
      // one long hold-off so the input side backs up
      if (!held && received == 200) begin
        held = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end
      phase++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else begin
        case ((phase / 64) % 3)
          0:       pop <= 1'b1;
          1:       pop <= ($urandom_range(0, 1) == 0);
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // abort when nothing moves for too long
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    kspe_pkg::item_t   it;
    kspe_pkg::result_t want;
    int                n_app, n_qry;
    rst        = 1'b1;
    push       = 1'b0;
    item       = '0;
    sent       = 0;
    burst_left = 0;
    tbl_count  = 0;
    tbl_end    = 0;
    for (int i = 0; i < SEGS; i++) begin
      tbl_start[i] = 0; tbl_vel[i] = 0; tbl_alt[i] = 0; tbl_accel[i] = 0; tbl_len[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NDIR; i++) begin
      it = '{directed_rows[i].mode, directed_rows[i].a, directed_rows[i].d,
             directed_rows[i].t};
      want = '0;
      want.segment_index = directed_rows[i].idx;
      want.status        = directed_rows[i].st;
      send_beat(it, directed_rows[i].fixed, want);
    end

    // random: mostly clear, build a profile, query it; some noise
    while (sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        it = '0;
        it.mode = kspe_pkg::MODE_CLEAR;
        if ($urandom_range(0, 4) != 0) send_pred(it);
        n_app = $urandom_range(1, 10);
        for (int k = 0; k < n_app; k++) begin
          it = {kspe_pkg::MODE_APPEND, rand_accel(), rand_duration(), 32'($urandom)};
          send_pred(it);
        end
        n_qry = $urandom_range(3, 12);
        for (int k = 0; k < n_qry; k++) begin
          it = {kspe_pkg::MODE_QUERY, 24'($urandom), 24'($urandom), rand_query_time()};
          send_pred(it);
        end
      end else begin
        it = {2'($urandom_range(0, 3)), 24'($urandom), 24'($urandom), 32'($urandom)};
        if (it.mode == kspe_pkg::MODE_CLEAR && $urandom_range(0, 1) == 0)
          it.mode = kspe_pkg::MODE_QUERY;
        send_pred(it);
      end
    end
    push <= 1'b0;

    // drain
    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/kspe_pkg.sv
rtl/core/kspe_front.sv
rtl/core/kspe_queue.sv
rtl/core/kspe_back.sv
rtl/core/kinematic_segment_profile_evaluator.sv
tb/sv/tb_kinematic_segment_profile_evaluator.sv
